// File: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared widths, CORDIC arctangent table and fixed-point helpers for the
// Euler frame rotation block.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int DATA_BITS    = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int COEF_FRAC    = ((61 - DATA_BITS) > 30) ? 30 : (61 - DATA_BITS);
  localparam int COEF_SH      = 30 - COEF_FRAC;
  // CORDIC datapath: Q1.30 with headroom
  localparam int CW           = 34;
  // phase register, 32-bit turn plus sign headroom
  localparam int ZW           = 33;
  localparam int QW           = 32;  // Q1.30 value incl. +-1.0
  localparam int CF_W         = COEF_FRAC + 2;
  localparam int ACC_W        = CF_W + DATA_BITS + 2;

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

  typedef logic signed [QW-1:0] q30_t;
  typedef logic signed [CF_W-1:0] coef_t;
  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    rot_t  roll;
    rot_t  pitch;
    rot_t  yaw;
    logic  mode;
    data_t vx;
    data_t vy;
    data_t vz;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_phase(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:  atan_phase = ZW'(536870912);
      5'd1:  atan_phase = ZW'(316933406);
      5'd2:  atan_phase = ZW'(167458907);
      5'd3:  atan_phase = ZW'(85004756);
      5'd4:  atan_phase = ZW'(42667331);
      5'd5:  atan_phase = ZW'(21354465);
      5'd6:  atan_phase = ZW'(10679838);
      5'd7:  atan_phase = ZW'(5340245);
      5'd8:  atan_phase = ZW'(2670163);
      5'd9:  atan_phase = ZW'(1335087);
      5'd10: atan_phase = ZW'(667544);
      5'd11: atan_phase = ZW'(333772);
      5'd12: atan_phase = ZW'(166886);
      5'd13: atan_phase = ZW'(83443);
      5'd14: atan_phase = ZW'(41722);
      5'd15: atan_phase = ZW'(20861);
      5'd16: atan_phase = ZW'(10430);
      5'd17: atan_phase = ZW'(5215);
      5'd18: atan_phase = ZW'(2608);
      5'd19: atan_phase = ZW'(1304);
      5'd20: atan_phase = ZW'(652);
      5'd21: atan_phase = ZW'(326);
      5'd22: atan_phase = ZW'(163);
      5'd23: atan_phase = ZW'(81);
      5'd24: atan_phase = ZW'(41);
      5'd25: atan_phase = ZW'(20);
      5'd26: atan_phase = ZW'(10);
      5'd27: atan_phase = ZW'(5);
      default: atan_phase = '0;
    endcase
  endfunction

  // Phase setup: widen the angle to a 32-bit turn, fold quadrants 2 and 3
  function automatic rot_t rot_init(input angle_t a);
    logic [31:0] ph;
    logic        flip;
    rot_t        r;
    ph   = {a, {(32 - ANGLE_BITS){1'b0}}};
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph + 32'h8000_0000;
    r.x    = CORDIC_X0;
    r.y    = '0;
    r.z    = ZW'($signed(ph));
    r.flip = flip;
    return r;
  endfunction

  // Q1.30 product rounded with floor shift
  function automatic q30_t mulq30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return QW'(p >>> 30);
  endfunction

  // Final result: flip sign if needed, clamp to +-1.0
  function automatic q30_t clamp_q30(input logic signed [CW-1:0] v, input logic flip);
    logic signed [CW:0] t;
    t = flip ? -(CW+1)'(v) : (CW+1)'(v);
    if (t > (CW+1)'(64'sd1073741824)) return QW'(32'sd1073741824);
    if (t < -(CW+1)'(64'sd1073741824)) return -QW'(32'sd1073741824);
    return QW'(t);
  endfunction

  function automatic coef_t to_coef(input logic signed [QW+1:0] e);
    logic signed [QW+1:0] t;
    t = e;
    if (COEF_SH > 0) t = (e + (QW+2)'((64'sd1 << COEF_SH) >> 1)) >>> COEF_SH;
    if (t > (QW+2)'(64'sd1 << COEF_FRAC)) return CF_W'(64'sd1 << COEF_FRAC);
    if (t < -(QW+2)'(64'sd1 << COEF_FRAC)) return -CF_W'(64'sd1 << COEF_FRAC);
    return CF_W'(t);
  endfunction

endpackage

// File: rtl/efr_if.sv
// ----------------------------------------------------------------------------
// efr_in_if / efr_out_if
// Valid/ready channels for angle+vector items and rotated vectors.
// ----------------------------------------------------------------------------
interface efr_in_if;
  import efr_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  angle_t roll_angle;
  angle_t pitch_angle;
  angle_t yaw_angle;
  data_t  vec_x;
  data_t  vec_y;
  data_t  vec_z;
  modport source (output valid, mode, roll_angle, pitch_angle, yaw_angle,
                  vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, mode, roll_angle, pitch_angle, yaw_angle,
                vec_x, vec_y, vec_z, output ready);
endinterface

interface efr_out_if;
  import efr_pkg::*;
  logic  valid;
  logic  ready;
  data_t out_x;
  data_t out_y;
  data_t out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// File: rtl/efr_cordic_cell.sv
// ----------------------------------------------------------------------------
// efr_cordic_cell
// One CORDIC rotation step for all three angles; hands its beat onward.
// ----------------------------------------------------------------------------
module efr_cordic_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [efr_pkg::STEP_W-1:0]     step,
  input  logic                           vld_in,
  input  efr_pkg::cell_t                 d_in,
  output logic                           vld_out,
  output efr_pkg::cell_t                 d_out
);
  import efr_pkg::*;

  cell_t d_nxt;

  function automatic rot_t rot_step(input rot_t r, input logic [STEP_W-1:0] i,
                                    input logic signed [ZW-1:0] a);
    rot_t o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    o  = r;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.z[ZW-1]) begin
      o.x = r.x - dx; o.y = r.y + dy; o.z = r.z - a;
    end else begin
      o.x = r.x + dx; o.y = r.y - dy; o.z = r.z + a;
    end
    return o;
  endfunction

  // rotate each angle by one step
  always_comb begin
    d_nxt       = d_in;
    d_nxt.roll  = rot_step(d_in.roll, step, atan_phase(step));
    d_nxt.pitch = rot_step(d_in.pitch, step, atan_phase(step));
    d_nxt.yaw   = rot_step(d_in.yaw, step, atan_phase(step));
  end

  // advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
    if (en) d_out <= d_nxt;
  end
endmodule

// File: rtl/efr_matrix.sv
// ----------------------------------------------------------------------------
// efr_matrix
// Builds the direction cosine matrix from sines/cosines and multiplies the
// vector. Five registered stages, stalled by en.
// ----------------------------------------------------------------------------
module efr_matrix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_in,
  input  efr_pkg::cell_t         d_in,
  output logic                   vld_out,
  output efr_pkg::data_t         ox,
  output efr_pkg::data_t         oy,
  output efr_pkg::data_t         oz
);
  import efr_pkg::*;

  typedef logic signed [QW+1:0] e_t;
  typedef logic signed [CF_W+DATA_BITS-1:0] p_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  logic [4:0] vld_r;
  // stage 1: sin/cos
  q30_t sf_r, cf_r, st_r, ct_r, sp_r, cp_r;
  logic mode1_r, mode2_r, mode3_r;
  data_t v1_r [3];
  data_t v2_r [3];
  data_t v3_r [3];
  // stage 2: first products
  q30_t sfst_r, cfst_r, ctcp_r, ctsp_r, cfsp_r, cfcp_r, sfsp_r, sfcp_r, sfct_r;
  q30_t cfct_r, st2_r, sp2_r, cp2_r;
  // stage 3: coefficients
  coef_t m_r [3][3];
  // stage 4: products with vector
  p_t pr_r [3][3];
  // stage 5: outputs
  data_t o_r [3];

  q30_t sfstcp, sfstsp, cfstcp, cfstsp;
  e_t e_c [3][3];
  coef_t k_c [3][3];
  acc_t sum_c [3];
  acc_t rnd_c [3];

  always_comb begin
    sfstcp = mulq30(sfst_r, cp2_r);
    sfstsp = mulq30(sfst_r, sp2_r);
    cfstcp = mulq30(cfst_r, cp2_r);
    cfstsp = mulq30(cfst_r, sp2_r);
    e_c[0][0] = e_t'(ctcp_r);
    e_c[0][1] = e_t'(ctsp_r);
    e_c[0][2] = -e_t'(st2_r);
    e_c[1][0] = e_t'(sfstcp) - e_t'(cfsp_r);
    e_c[1][1] = e_t'(sfstsp) + e_t'(cfcp_r);
    e_c[1][2] = e_t'(sfct_r);
    e_c[2][0] = e_t'(cfstcp) + e_t'(sfsp_r);
    e_c[2][1] = e_t'(cfstsp) - e_t'(sfcp_r);
    e_c[2][2] = e_t'(cfct_r);
    // select matrix or transpose
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k_c[i][j] = mode3_r ? m_r[j][i] : m_r[i][j];
      end
    end
    // sum and round
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = acc_t'(pr_r[i][0]) + acc_t'(pr_r[i][1]) + acc_t'(pr_r[i][2]);
      rnd_c[i] = (sum_c[i] + acc_t'(64'sd1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_in};
    end
    if (en) begin
      // finish CORDIC
      cf_r <= clamp_q30(d_in.roll.x, d_in.roll.flip);
      sf_r <= clamp_q30(d_in.roll.y, d_in.roll.flip);
      ct_r <= clamp_q30(d_in.pitch.x, d_in.pitch.flip);
      st_r <= clamp_q30(d_in.pitch.y, d_in.pitch.flip);
      cp_r <= clamp_q30(d_in.yaw.x, d_in.yaw.flip);
      sp_r <= clamp_q30(d_in.yaw.y, d_in.yaw.flip);
      mode1_r <= d_in.mode;
      v1_r[0] <= d_in.vx; v1_r[1] <= d_in.vy; v1_r[2] <= d_in.vz;
      // pairwise products
      sfst_r <= mulq30(sf_r, st_r);
      cfst_r <= mulq30(cf_r, st_r);
      ctcp_r <= mulq30(ct_r, cp_r);
      ctsp_r <= mulq30(ct_r, sp_r);
      cfsp_r <= mulq30(cf_r, sp_r);
      cfcp_r <= mulq30(cf_r, cp_r);
      sfsp_r <= mulq30(sf_r, sp_r);
      sfcp_r <= mulq30(sf_r, cp_r);
      sfct_r <= mulq30(sf_r, ct_r);
      cfct_r <= mulq30(cf_r, ct_r);
      st2_r <= st_r; sp2_r <= sp_r; cp2_r <= cp_r;
      mode2_r <= mode1_r; v2_r <= v1_r;
      // coefficients
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= to_coef(e_c[i][j]);
        end
      end
      mode3_r <= mode2_r; v3_r <= v2_r;
      // vector products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= p_t'(k_c[i][j]) * p_t'(v3_r[j]);
        end
      end
      // sum, round, saturate
      for (int i = 0; i < 3; i++) begin
        if (rnd_c[i] > acc_t'({1'b0, {(DATA_BITS-1){1'b1}}}))
          o_r[i] <= {1'b0, {(DATA_BITS-1){1'b1}}};
        else if (rnd_c[i] < -acc_t'({1'b0, {(DATA_BITS-1){1'b1}}}) - acc_t'(1))
          o_r[i] <= {1'b1, {(DATA_BITS-1){1'b0}}};
        else
          o_r[i] <= DATA_BITS'(rnd_c[i]);
      end
    end
  end

  assign vld_out = vld_r[4];
  assign ox = o_r[0];
  assign oy = o_r[1];
  assign oz = o_r[2];
endmodule

// File: rtl/euler_frame_rotation.sv
// ----------------------------------------------------------------------------
// euler_frame_rotation
// ZYX Euler direction cosine rotation of a Q16.16 vector.
// Pipeline: 1 setup stage, 28 CORDIC cells, 5 matrix stages, 1 output reg.
// Throughput: one item per cycle; the whole pipe stalls only when the
// output register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits; no state kept.
// ----------------------------------------------------------------------------
module euler_frame_rotation (
  input logic   clk,
  input logic   rst_n,
  efr_in_if.sink    in_ch,
  efr_out_if.source out_ch
);
  import efr_pkg::*;

  logic  en;
  logic  vld_c [CORDIC_STEPS+1];
  cell_t d_c   [CORDIC_STEPS+1];
  logic  mvld;
  data_t mx, my, mz;
  logic  out_vld_r;
  data_t ox_r, oy_r, oz_r;

  // pipe moves whenever the output slot is free or being drained
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // setup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c[0] <= 1'b0;
    end else if (en) begin
      vld_c[0] <= in_ch.valid;
    end
    if (en) begin
      d_c[0].roll  <= rot_init(in_ch.roll_angle);
      d_c[0].pitch <= rot_init(in_ch.pitch_angle);
      d_c[0].yaw   <= rot_init(in_ch.yaw_angle);
      d_c[0].mode  <= in_ch.mode;
      d_c[0].vx    <= in_ch.vec_x;
      d_c[0].vy    <= in_ch.vec_y;
      d_c[0].vz    <= in_ch.vec_z;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    efr_cordic_cell u_cell (
      .clk, .rst_n, .en,
      .step   (STEP_W'(g)),
      .vld_in (vld_c[g]),
      .d_in   (d_c[g]),
      .vld_out(vld_c[g+1]),
      .d_out  (d_c[g+1])
    );
  end

  efr_matrix u_matrix (
    .clk, .rst_n, .en,
    .vld_in (vld_c[CORDIC_STEPS]),
    .d_in   (d_c[CORDIC_STEPS]),
    .vld_out(mvld),
    .ox     (mx),
    .oy     (my),
    .oz     (mz)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= mvld;
    end
    if (en) begin
      ox_r <= mx; oy_r <= my; oz_r <= mz;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;
endmodule

// File: tb/sv/euler_frame_rotation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_frame_rotation_tb
// Drives angle/vector beats through the Euler frame rotation block under
// several idle and stall patterns and checks every rotated vector against a
// bit-exact CORDIC and direction cosine predictor.
// ----------------------------------------------------------------------------
module euler_frame_rotation_tb;
  import efr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic   mode;
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
    data_t  vx;
    data_t  vy;
    data_t  vz;
  } rot_req_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
  } rot_vec_t;

  logic clk;
  logic rst_n;

  efr_in_if  in_ch ();
  efr_out_if out_ch ();

  euler_frame_rotation dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rot_req_t pending_q[$];
  rot_vec_t expected_q[$];
  rot_vec_t pred;
  int       mismatches;
  int       src_idle_pct;
  int       snk_stall_pct;
  int       hold_off;
  int       idle_cycles;

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor shift of a signed 64-bit value
  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
      20, 10, 5};
    return tbl[i];
  endfunction

  // Sine and cosine in Q1.30 by 28-step CORDIC with quadrant fold
  task automatic angle_sincos(input angle_t a, output longint s, output longint c);
    logic [31:0] ph;
    bit          fold;
    longint      x, y, z, dx, dy;
    ph   = {a, {(32 - ANGLE_BITS){1'b0}}};
    fold = ph[31] ^ ph[30];
    if (fold) ph = ph + 32'h8000_0000;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (fold) begin
      x = -x; y = -y;
    end
    c = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
    s = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
  endtask

  function automatic longint qmul(longint a, longint b);
    return asr64(a * b + (64'sd1 << 29), 30);
  endfunction

  function automatic longint quant_coef(longint e);
    int sh;
    sh = 30 - COEF_FRAC;
    if (sh > 0) e = asr64(e + (64'sd1 << (sh - 1)), sh);
    return clip(e, -(64'sd1 << COEF_FRAC), 64'sd1 << COEF_FRAC);
  endfunction

  // Predict the rotated vector for one request
  task automatic rotate_vector(input rot_req_t r, output rot_vec_t o);
    longint sf, cf, st, ct, sp, cp;
    longint m[3][3];
    longint v[3];
    longint acc, res, k;
    longint maxv, minv;
    angle_sincos(r.roll, sf, cf);
    angle_sincos(r.pitch, st, ct);
    angle_sincos(r.yaw, sp, cp);
    v[0] = longint'(r.vx);
    v[1] = longint'(r.vy);
    v[2] = longint'(r.vz);
    m[0][0] = qmul(ct, cp);
    m[0][1] = qmul(ct, sp);
    m[0][2] = -st;
    m[1][0] = qmul(qmul(sf, st), cp) - qmul(cf, sp);
    m[1][1] = qmul(qmul(sf, st), sp) + qmul(cf, cp);
    m[1][2] = qmul(sf, ct);
    m[2][0] = qmul(qmul(cf, st), cp) + qmul(sf, sp);
    m[2][1] = qmul(qmul(cf, st), sp) - qmul(sf, cp);
    m[2][2] = qmul(cf, ct);
    maxv = (64'sd1 <<< (DATA_BITS - 1)) - 1;
    minv = -maxv - 1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = quant_coef(m[i][j]);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        k = r.mode ? m[j][i] : m[i][j];
        acc += k * v[j];
      end
      res = clip(asr64(acc + (64'sd1 << (COEF_FRAC - 1)), COEF_FRAC), minv, maxv);
      if (i == 0) o.x = data_t'(res);
      else if (i == 1) o.y = data_t'(res);
      else o.z = data_t'(res);
    end
  endtask

  function automatic data_t rand_data();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return data_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return angle_t'({$urandom_range(0, 3), 14'd0});
      2: return angle_t'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 4) - 2);
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic rot_req_t mk_req(logic md, angle_t ra, angle_t pa, angle_t ya,
                                      data_t x, data_t y, data_t z);
    rot_req_t r;
    r.mode = md; r.roll = ra; r.pitch = pa; r.yaw = ya;
    r.vx = x; r.vy = y; r.vz = z;
    return r;
  endfunction

  // Driver: offer queued beats, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rotate_vector({in_ch.mode, in_ch.roll_angle, in_ch.pitch_angle,
                       in_ch.yaw_angle, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z},
                      pred);
        expected_q.push_back(pred);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          rot_req_t r;
          r = pending_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= r.mode;
          in_ch.roll_angle  <= r.roll;
          in_ch.pitch_angle <= r.pitch;
          in_ch.yaw_angle   <= r.yaw;
          in_ch.vec_x       <= r.vx;
          in_ch.vec_y       <= r.vy;
          in_ch.vec_z       <= r.vz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result beats, compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat x=%0d y=%0d z=%0d",
                     out_ch.out_x, out_ch.out_y, out_ch.out_z);
        end else begin
          rot_vec_t e;
          e = expected_q.pop_front();
          if (e.x !== out_ch.out_x || e.y !== out_ch.out_y || e.z !== out_ch.out_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       e.x, e.y, e.z, out_ch.out_x, out_ch.out_y, out_ch.out_z);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off     <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no beat moved
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || hold_off > 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        pending_q.push_back(mk_req(1'($urandom), rand_angle(), rand_angle(), rand_angle(),
                                   rand_data(), rand_data(), rand_data()));
      else
        pending_q.push_back(mk_req(1'($urandom), angle_t'($urandom), angle_t'($urandom),
                                   angle_t'($urandom), data_t'($urandom),
                                   data_t'($urandom), data_t'($urandom)));
    end
    while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = 1'b0;
    in_ch.roll_angle  = '0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle   = '0;
    in_ch.vec_x  = '0;
    in_ch.vec_y  = '0;
    in_ch.vec_z  = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    hold_off     = 0;
    idle_cycles  = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, quarter turns, pi, extremes, both modes
    for (int md = 0; md < 2; md++) begin
      pending_q.push_back(mk_req(1'(md), 16'h0000, 16'h0000, 16'h0000, 32'sh0001_0000,
                                 32'sh0002_0000, -32'sh0003_0000));
      pending_q.push_back(mk_req(1'(md), 16'h4000, 16'h0000, 16'h0000, 32'sh0001_0000,
                                 32'sh0001_0000, 32'sh0001_0000));
      pending_q.push_back(mk_req(1'(md), 16'h0000, 16'h4000, 16'h0000, 32'sh0001_0000,
                                 32'sh0000_0000, 32'sh0001_0000));
      pending_q.push_back(mk_req(1'(md), 16'h0000, 16'h0000, 16'hC000, 32'sh0001_0000,
                                 32'sh0002_0000, 32'sh0000_0000));
      pending_q.push_back(mk_req(1'(md), 16'h8000, 16'h8000, 16'h8000, 32'sh7FFF_FFFF,
                                 32'sh8000_0000, 32'sh1234_5678));
      pending_q.push_back(mk_req(1'(md), 16'h2000, 16'h2000, 16'h2000, 32'sh7FFF_FFFF,
                                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      pending_q.push_back(mk_req(1'(md), 16'hE000, 16'h6000, 16'h7FFF, 32'sh8000_0000,
                                 32'sh8000_0000, 32'sh8000_0000));
      pending_q.push_back(mk_req(1'(md), 16'h7FFF, 16'h8001, 16'hFFFF, -32'sh0000_0001,
                                 32'sh0000_0001, 32'sh0000_0000));
      pending_q.push_back(mk_req(1'(md), 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'shFFFF_FFFF,
                                 32'sh7FFF_FFFF, 32'sh8000_0000));
      pending_q.push_back(mk_req(1'(md), 16'h5555, 16'hAAAA, 16'h1234, 32'sh5555_5555,
                                 32'shAAAA_AAAA, 32'sh0F0F_0F0F));
    end
    while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);

    run_phase(400, 0, 0);
    run_phase(400, 48, 0);
    run_phase(400, 0, 48);
    // Long receiver hold-off so the pipe fills and backpressures
    hold_off = 300;
    run_phase(430, 28, 28);

    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
